// ===== rtl/core/fhpd_pkg.sv =====
package fhpd_pkg;

   localparam int TYPE_BYTES      = 1;
   localparam int RES_TWO_BYTES   = 1;
   localparam int MAX_FRAME_BYTES = 8192;
   localparam int CRC_BYTES       = 4;
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
   localparam int QDEPTH          = 2;

   localparam logic [7:0] KIND_AGG = 8'd8;
   localparam logic [7:0] KIND_NAV_A = 8'd4;
   localparam logic [7:0] KIND_NAV_B = 8'd5;
   localparam logic [7:0] KIND_PLAIN_MAX = 8'd5;

   localparam logic [2:0] CSR_INDEX   = 3'd0;
   localparam logic [2:0] CSR_DEST    = 3'd1;
   localparam logic [2:0] CSR_SRC     = 3'd2;
   localparam logic [2:0] CSR_NTRANS  = 3'd3;
   localparam logic [2:0] CSR_RESONE  = 3'd4;
   localparam logic [2:0] CSR_PAYLEN  = 3'd5;
   localparam logic [2:0] CSR_SELF    = 3'd6;
   localparam logic [2:0] CSR_OWN     = 3'd7;

   typedef enum logic [1:0] {
      MODE_IDLE, MODE_PLAIN, MODE_AGG, MODE_DROP
   } mode_type;

   typedef struct packed {
      logic [7:0]  kind;
      logic [31:0] index;
      logic [31:0] dest;
      logic [31:0] source;
      logic [31:0] ntrans;
      logic [31:0] res_one;
      logic [31:0] res_two;
      logic [31:0] paylen;
      logic [5:0]  hdr_len;
      logic [31:0] nav;
      logic [10:0] sub_number;
      logic        is_sub;
   } result_type;

   function automatic logic [2:0] clamp4(input logic [2:0] v);
      return (v > 3'd4) ? 3'd4 : v;
   endfunction

endpackage

// ===== rtl/core/frame_header_parser_with_deaggregation.sv =====
// A result is written into the result queue by the req_ beat that ends it and leaves on rsp_ from there.
// Throughput: one byte per cycle while req_stall is low; the parser front has no busy state.
// A two-entry result queue decouples the front from rsp_stall; req_stall rises
// only while the queue is full.
// Reset: synchronous, active high; clears parser state and queue, sets field widths
// to one byte, self check off and own address zero.
module frame_header_parser_with_deaggregation
   import fhpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_kind_out,
   output logic [31:0] rsp_index_out,
   output logic [31:0] rsp_dest_out,
   output logic [31:0] rsp_source_out,
   output logic [31:0] rsp_ntrans_out,
   output logic [31:0] rsp_reserved_one_out,
   output logic [31:0] rsp_reserved_two_out,
   output logic [31:0] rsp_paylen_out,
   output logic [5:0]  rsp_hdr_len_out,
   output logic [31:0] rsp_nav_out,
   output logic [10:0] rsp_sub_number,
   output logic        rsp_is_sub,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [2:0]  wi_ff, wd_ff, ws_ff, wn_ff, wr_ff, wp_ff;
   logic        self_ff;
   logic [31:0] own_ff;
   logic        full, fv;
   result_type  fres, q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff <= 3'd1; wd_ff <= 3'd1; ws_ff <= 3'd1; wn_ff <= 3'd1;
         wr_ff <= 3'd1; wp_ff <= 3'd1; self_ff <= 1'b0; own_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_INDEX:  wi_ff <= csr_data[2:0];
            CSR_DEST:   wd_ff <= csr_data[2:0];
            CSR_SRC:    ws_ff <= csr_data[2:0];
            CSR_NTRANS: wn_ff <= csr_data[2:0];
            CSR_RESONE: wr_ff <= csr_data[2:0];
            CSR_PAYLEN: wp_ff <= csr_data[2:0];
            CSR_SELF:   self_ff <= csr_data[0];
            CSR_OWN:    own_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = full;

   fhpd_front u_front (
      .clock, .reset,
      .in_valid(req_valid && !full),
      .data_byte(req_data_byte), .frame_end(req_frame_end),
      .w_index(wi_ff), .w_dest(wd_ff), .w_src(ws_ff), .w_ntrans(wn_ff),
      .w_resone(wr_ff), .w_paylen(wp_ff),
      .self_check_on(self_ff), .own_address(own_ff),
      .res_valid(fv), .res(fres)
   );

   fhpd_back u_back (
      .clock, .reset,
      .push(fv), .push_data(fres), .full,
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_data(q_out)
   );

   assign rsp_kind_out = q_out.kind;
   assign rsp_index_out = q_out.index;
   assign rsp_dest_out = q_out.dest;
   assign rsp_source_out = q_out.source;
   assign rsp_ntrans_out = q_out.ntrans;
   assign rsp_reserved_one_out = q_out.res_one;
   assign rsp_reserved_two_out = q_out.res_two;
   assign rsp_paylen_out = q_out.paylen;
   assign rsp_hdr_len_out = q_out.hdr_len;
   assign rsp_nav_out = q_out.nav;
   assign rsp_sub_number = q_out.sub_number;
   assign rsp_is_sub = q_out.is_sub;

endmodule

// ===== rtl/core/fhpd_front.sv =====
module fhpd_front
   import fhpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [7:0]  data_byte,
   input  logic        frame_end,
   input  logic [2:0]  w_index,
   input  logic [2:0]  w_dest,
   input  logic [2:0]  w_src,
   input  logic [2:0]  w_ntrans,
   input  logic [2:0]  w_resone,
   input  logic [2:0]  w_paylen,
   input  logic        self_check_on,
   input  logic [31:0] own_address,
   output logic        res_valid,
   output result_type  res
);

   mode_type          mode_ff, mode_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  slot_ff, slot_in;
   logic [7:0]        type_ff, type_in;
   logic [31:0]       acc_ff [7], acc_in [7];
   logic [31:0]       nav_ff, nav_in, mpdu_ff, mpdu_in;
   logic [10:0]       sub_ff, sub_in;

   logic [5:0]  w [7];
   logic [5:0]  hl, dl, dl_start;
   logic [POS_W-1:0] pos;
   mode_type    m;
   logic [7:0]  t;
   logic        navk;
   logic [33:0] slot_len;
   logic [32:0] q;

   always_comb begin
      w[0] = {3'd0, clamp4(w_index)};
      w[1] = {3'd0, clamp4(w_dest)};
      w[2] = {3'd0, clamp4(w_src)};
      w[3] = {3'd0, clamp4(w_ntrans)};
      w[4] = {3'd0, clamp4(w_resone)};
      w[5] = 6'(RES_TWO_BYTES);
      w[6] = {3'd0, clamp4(w_paylen)};
      hl = 6'(TYPE_BYTES) + w[0] + w[1] + w[2] + w[3] + w[4] + w[5] + w[6];
      dl_start = 6'(TYPE_BYTES) + w[4];
      dl = dl_start + w[6];
   end

   // place byte at header offset hq into the accumulator it belongs to
   function automatic void place(input logic [32:0] hq, input logic [7:0] b,
                                 inout logic [31:0] a [7], input logic [5:0] ww [7]);
      logic [33:0] off;
      logic        done;
      off = 34'(TYPE_BYTES);
      done = (hq < 33'(TYPE_BYTES));
      for (int i = 0; i < 7; i++) begin
         if (!done && {1'b0, hq} < off + 34'(ww[i])) begin
            a[i] = {a[i][23:0], b};
            done = 1'b1;
         end
         off = off + 34'(ww[i]);
      end
   endfunction

   always_comb begin
      mode_in = mode_ff; pos_in = pos_ff; slot_in = slot_ff; type_in = type_ff;
      acc_in = acc_ff; nav_in = nav_ff; mpdu_in = mpdu_ff; sub_in = sub_ff;
      res_valid = 1'b0;
      res = '0;
      q = '0;
      slot_len = '0;
      navk = 1'b0;
      pos = (mode_ff == MODE_IDLE) ? '0 : pos_ff;
      m = mode_ff;
      t = type_ff;
      if (in_valid) begin
         if (mode_ff == MODE_IDLE) begin
            t = data_byte;
            type_in = data_byte;
            for (int i = 0; i < 7; i++) acc_in[i] = '0;
            nav_in = '0; mpdu_in = '0; slot_in = '0; sub_in = '0;
            if (data_byte >= 8'd1 && data_byte <= KIND_PLAIN_MAX) m = MODE_PLAIN;
            else if (data_byte == KIND_AGG) m = MODE_AGG;
            else m = MODE_DROP;
         end
         navk = (t == KIND_NAV_A) || (t == KIND_NAV_B);
         mode_in = m;
         if (m == MODE_PLAIN) begin
            if ({1'b0, pos} < (POS_W+1)'(hl))
               place(33'(pos), data_byte, acc_in, w);
            else if (navk && 33'(pos - POS_W'(hl)) < {1'b0, acc_in[6]})
               nav_in = {nav_in[23:0], data_byte};
            res.index = acc_in[0]; res.dest = acc_in[1]; res.source = acc_in[2];
            res.ntrans = acc_in[3]; res.res_one = acc_in[4]; res.res_two = acc_in[5];
            res.paylen = acc_in[6]; res.hdr_len = hl;
            if (frame_end && 33'(pos) + 33'd1 >= 33'(hl) &&
                !(self_check_on && acc_in[2] == own_address)) begin
               res_valid = 1'b1;
               res.kind = t;
               res.nav = navk ? nav_in : '0;
            end
         end else if (m == MODE_AGG) begin
            if ({1'b0, pos} < (POS_W+1)'(dl) && {1'b0, pos} >= (POS_W+1)'(dl_start))
               mpdu_in = {mpdu_in[23:0], data_byte};
            slot_len = 34'(dl) + 34'(mpdu_in) + 34'(CRC_BYTES);
            if ({1'b0, slot_in} >= (POS_W+1)'(dl)) begin
               q = 33'(slot_in - POS_W'(dl));
               if (q < {1'b0, mpdu_in} && q < 33'(hl))
                  place(q, data_byte, acc_in, w);
            end
            res.index = acc_in[0]; res.dest = acc_in[1]; res.source = acc_in[2];
            res.ntrans = acc_in[3]; res.res_one = acc_in[4]; res.res_two = acc_in[5];
            res.paylen = acc_in[6]; res.hdr_len = hl;
            if (34'(slot_in) + 34'd1 >= slot_len) begin
               if (mpdu_in >= 32'(hl) && !(self_check_on && acc_in[2] == own_address)) begin
                  res_valid = 1'b1;
                  res.kind = KIND_AGG;
                  res.sub_number = sub_in;
                  res.is_sub = 1'b1;
               end
               sub_in = sub_in + 11'd1;
               slot_in = '0;
               for (int i = 0; i < 7; i++) acc_in[i] = '0;
               nav_in = '0;
            end else begin
               slot_in = slot_in + 1'b1;
            end
         end
         if (frame_end) begin
            mode_in = MODE_IDLE; pos_in = '0;
         end else if (pos == POS_W'(MAX_FRAME_BYTES - 1)) begin
            mode_in = MODE_DROP; pos_in = pos;
         end else begin
            pos_in = pos + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE; pos_ff <= '0; slot_ff <= '0; type_ff <= '0;
         for (int i = 0; i < 7; i++) acc_ff[i] <= '0;
         nav_ff <= '0; mpdu_ff <= '0; sub_ff <= '0;
      end else begin
         mode_ff <= mode_in; pos_ff <= pos_in; slot_ff <= slot_in; type_ff <= type_in;
         acc_ff <= acc_in; nav_ff <= nav_in; mpdu_ff <= mpdu_in; sub_ff <= sub_in;
      end
   end

endmodule

// ===== rtl/core/fhpd_back.sv =====
module fhpd_back
   import fhpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   result_type       mem_ff [QDEPTH];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   logic             pop;

   assign pop = out_valid && !out_stall;
   assign out_valid = (cnt_ff != 2'd0);
   assign full = (cnt_ff == 2'(QDEPTH));
   assign out_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QDEPTH)) else $error("queue count out of range");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - 2'd1) else $error("pop lost");
`endif

endmodule

// ===== tb/sv/fhpd_checker.sv =====
module fhpd_checker
   import fhpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_end,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_kind_out,
   input  logic [31:0] rsp_index_out,
   input  logic [31:0] rsp_dest_out,
   input  logic [31:0] rsp_source_out,
   input  logic [31:0] rsp_ntrans_out,
   input  logic [31:0] rsp_reserved_one_out,
   input  logic [31:0] rsp_reserved_two_out,
   input  logic [31:0] rsp_paylen_out,
   input  logic [5:0]  rsp_hdr_len_out,
   input  logic [31:0] rsp_nav_out,
   input  logic [10:0] rsp_sub_number,
   input  logic        rsp_is_sub,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fails,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // field order: index, dest, source, ntrans, res_one, res_two, paylen (width_reg has no res_two)
   logic [2:0]  width_reg [0:5];
   logic        self_on;
   logic [31:0] own_addr;

   mode_type        mode;
   int unsigned     byte_pos;
   longint unsigned slot_pos;
   logic [7:0]      kind_reg;
   logic [31:0]     field_acc [0:6];
   logic [31:0]     nav_acc;
   logic [31:0]     mpdu_len;
   logic [10:0]     sub_count;

   result_type header_q[$];

   function automatic int unsigned fw(int i);
      int unsigned v;
      if (i == 5) v = RES_TWO_BYTES;
      else if (i == 6) v = width_reg[5];
      else v = width_reg[i];
      return (v > 4) ? 4 : v;
   endfunction

   function automatic int unsigned header_len();
      int unsigned s;
      s = TYPE_BYTES;
      for (int i = 0; i < 7; i++) s += fw(i);
      return s;
   endfunction

   function void clear_fields();
      for (int i = 0; i < 7; i++) field_acc[i] = '0;
      nav_acc = '0;
   endfunction

   function void place_header_byte(longint unsigned q, logic [7:0] b);
      longint unsigned off;
      off = TYPE_BYTES;
      if (q < TYPE_BYTES) return;
      for (int i = 0; i < 7; i++) begin
         if (q < off + fw(i)) begin
            field_acc[i] = {field_acc[i][23:0], b};
            return;
         end
         off += fw(i);
      end
   endfunction

   function void queue_header(logic [7:0] kind, logic [31:0] nav, logic [10:0] sub,
                              logic issub);
      result_type r;
      if (self_on && field_acc[2] == own_addr) return;
      r.kind = kind;
      r.index = field_acc[0];
      r.dest = field_acc[1];
      r.source = field_acc[2];
      r.ntrans = field_acc[3];
      r.res_one = field_acc[4];
      r.res_two = field_acc[5];
      r.paylen = field_acc[6];
      r.hdr_len = 6'(header_len());
      r.nav = nav;
      r.sub_number = sub;
      r.is_sub = issub;
      header_q.push_back(r);
   endfunction

   function void parse_beat(logic [7:0] b, logic last);
      int unsigned     pos, hl;
      longint unsigned dl, slot_len;
      logic            nav_kind;
      pos = (mode == MODE_IDLE) ? 0 : byte_pos;
      hl = header_len();
      if (mode == MODE_IDLE) begin
         kind_reg = b;
         clear_fields();
         mpdu_len = '0;
         slot_pos = 0;
         sub_count = '0;
         if (b >= 1 && b <= KIND_PLAIN_MAX) mode = MODE_PLAIN;
         else if (b == KIND_AGG) mode = MODE_AGG;
         else mode = MODE_DROP;
      end
      nav_kind = (kind_reg == KIND_NAV_A || kind_reg == KIND_NAV_B);
      if (mode == MODE_PLAIN) begin
         if (pos < hl) place_header_byte(pos, b);
         else if (nav_kind && longint'(pos - hl) < longint'(field_acc[6]))
            nav_acc = {nav_acc[23:0], b};
         if (last && pos + 1 >= hl)
            queue_header(kind_reg, nav_kind ? nav_acc : 32'd0, 11'd0, 1'b0);
      end else if (mode == MODE_AGG) begin
         dl = TYPE_BYTES + fw(4) + fw(6);
         if (pos < dl && pos >= TYPE_BYTES + fw(4)) mpdu_len = {mpdu_len[23:0], b};
         slot_len = dl + longint'(mpdu_len) + CRC_BYTES;
         if (slot_pos >= dl) begin
            if (slot_pos - dl < mpdu_len && slot_pos - dl < hl)
               place_header_byte(slot_pos - dl, b);
         end
         if (slot_pos + 1 >= slot_len) begin
            if (mpdu_len >= hl) queue_header(KIND_AGG, 32'd0, sub_count, 1'b1);
            sub_count = sub_count + 11'd1;
            slot_pos = 0;
            clear_fields();
         end else begin
            slot_pos++;
         end
      end
      if (last) begin
         mode = MODE_IDLE;
         byte_pos = 0;
      end else if (pos >= MAX_FRAME_BYTES - 1) begin
         mode = MODE_DROP;
         byte_pos = MAX_FRAME_BYTES - 1;
      end else begin
         byte_pos = pos + 1;
      end
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         for (int i = 0; i < 6; i++) width_reg[i] = 3'd1;
         self_on = 1'b0;
         own_addr = '0;
         mode = MODE_IDLE;
         byte_pos = 0;
         slot_pos = 0;
         kind_reg = '0;
         clear_fields();
         mpdu_len = '0;
         sub_count = '0;
         header_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (header_q.size() == 0) begin
               $error("result beat with no expected header");
               fails++;
            end else begin
               e = header_q.pop_front();
               check_field("kind_out", e.kind, rsp_kind_out);
               check_field("index_out", e.index, rsp_index_out);
               check_field("dest_out", e.dest, rsp_dest_out);
               check_field("source_out", e.source, rsp_source_out);
               check_field("ntrans_out", e.ntrans, rsp_ntrans_out);
               check_field("reserved_one_out", e.res_one, rsp_reserved_one_out);
               check_field("reserved_two_out", e.res_two, rsp_reserved_two_out);
               check_field("paylen_out", e.paylen, rsp_paylen_out);
               check_field("hdr_len_out", e.hdr_len, rsp_hdr_len_out);
               check_field("nav_out", e.nav, rsp_nav_out);
               check_field("sub_number", e.sub_number, rsp_sub_number);
               check_field("is_sub", e.is_sub, rsp_is_sub);
            end
         end
         if (req_valid && !req_stall) parse_beat(req_data_byte, req_frame_end);
         if (csr_write) begin
            case (csr_index)
               CSR_INDEX: width_reg[0] = csr_data[2:0];
               CSR_DEST: width_reg[1] = csr_data[2:0];
               CSR_SRC: width_reg[2] = csr_data[2:0];
               CSR_NTRANS: width_reg[3] = csr_data[2:0];
               CSR_RESONE: width_reg[4] = csr_data[2:0];
               CSR_PAYLEN: width_reg[5] = csr_data[2:0];
               CSR_SELF: self_on = csr_data[0];
               CSR_OWN: own_addr = csr_data;
               default: ;
            endcase
         end
      end
      pending = header_q.size();
   end

   initial begin
      fails = 0;
      pending = 0;
   end

endmodule

// ===== tb/sv/tb_frame_header_parser_with_deaggregation.sv =====
module tb_frame_header_parser_with_deaggregation;
   import fhpd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_kind_out;
   logic [31:0] rsp_index_out, rsp_dest_out, rsp_source_out, rsp_ntrans_out;
   logic [31:0] rsp_reserved_one_out, rsp_reserved_two_out, rsp_paylen_out;
   logic [5:0]  rsp_hdr_len_out;
   logic [31:0] rsp_nav_out;
   logic [10:0] rsp_sub_number;
   logic        rsp_is_sub;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          fails, pending;

   int          beats_sent = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          quiet = 1'b0;
   int unsigned cfg_w [0:5];
   logic [31:0] cfg_own;
   logic [7:0]  frame_q[$];

   always #2 clock = ~clock;

   frame_header_parser_with_deaggregation u_dut (.*);

   fhpd_checker u_checker (.*);

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 5);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left = draw_gap();
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left != 0);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("[frame_header_parser_with_deaggregation] ERROR");
         $finish;
      end
   end

   function automatic int unsigned eff(int i);
      int unsigned v;
      v = (i == 6) ? RES_TWO_BYTES : cfg_w[i];
      return (v > 4) ? 4 : v;
   endfunction

   function automatic int unsigned hdr_bytes();
      int unsigned s;
      s = TYPE_BYTES + eff(6);
      for (int i = 0; i < 6; i++) s += eff(i);
      return s;
   endfunction

   function void push_field(logic [31:0] v, int unsigned w);
      for (int k = int'(w) - 1; k >= 0; k--) frame_q.push_back(v[8*k +: 8]);
   endfunction

   // type byte and header; returns the payload length written
   function automatic int unsigned push_header(logic [7:0] kind, int unsigned plen);
      logic [31:0] src;
      frame_q.push_back(kind);
      push_field($urandom, eff(0));
      push_field($urandom, eff(1));
      src = ($urandom_range(0, 2) == 0) ? cfg_own : $urandom;
      push_field(src, eff(2));
      push_field($urandom, eff(3));
      push_field($urandom, eff(4));
      push_field($urandom, eff(6));
      if (eff(5) == 0) plen = 0;
      push_field(plen, eff(5));
      return plen;
   endfunction

   task automatic send_frame();
      int gap;
      foreach (frame_q[i]) begin
         gap = draw_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data_byte <= frame_q[i];
         req_frame_end <= (i == frame_q.size() - 1);
         @(posedge clock);
         while (req_stall) @(posedge clock);
         beats_sent++;
      end
      req_valid <= 1'b0;
      frame_q.delete();
   endtask

   task automatic plain_frame(logic [7:0] kind, int cut);
      int unsigned plen, n;
      plen = push_header(kind, $urandom_range(0, 10));
      n = plen + $urandom_range(0, 2);
      repeat (n) frame_q.push_back($urandom);
      if (cut > 0 && cut < frame_q.size()) frame_q = frame_q[0 : cut - 1];
      send_frame();
   endtask

   task automatic agg_frame();
      int unsigned hl, mlen, slots;
      logic [7:0] slot_q[$];
      hl = hdr_bytes();
      mlen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, hl) : $urandom_range(hl, hl + 6);
      if (eff(5) == 0) mlen = 0;
      slots = $urandom_range(1, 4);
      for (int s = 0; s < slots; s++) begin
         frame_q.push_back(KIND_AGG);
         push_field($urandom, eff(4));
         push_field((s == 0) ? mlen : $urandom, eff(5));
         slot_q = frame_q;
         frame_q.delete();
         void'(push_header($urandom, $urandom_range(0, 10)));
         while (frame_q.size() < mlen) frame_q.push_back($urandom);
         if (mlen == 0) frame_q.delete();
         else frame_q = frame_q[0 : mlen - 1];
         frame_q = {slot_q, frame_q};
         repeat (CRC_BYTES) frame_q.push_back($urandom);
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 5)) frame_q.push_back($urandom);
      send_frame();
   endtask

   task automatic noise_frame();
      logic [7:0] kind;
      do kind = $urandom; while ((kind >= 1 && kind <= KIND_PLAIN_MAX) || kind == KIND_AGG);
      frame_q.push_back(kind);
      repeat ($urandom_range(0, 7)) frame_q.push_back($urandom);
      send_frame();
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
   endtask

   task automatic configure(int unsigned w0, int unsigned w1, int unsigned w2,
                            int unsigned w3, int unsigned w4, int unsigned w5,
                            logic self_bit, logic [31:0] own);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      cfg_w[0] = w0; cfg_w[1] = w1; cfg_w[2] = w2;
      cfg_w[3] = w3; cfg_w[4] = w4; cfg_w[5] = w5;
      cfg_own = own;
      write_reg(CSR_INDEX, w0);
      write_reg(CSR_DEST, w1);
      write_reg(CSR_SRC, w2);
      write_reg(CSR_NTRANS, w3);
      write_reg(CSR_RESONE, w4);
      write_reg(CSR_PAYLEN, w5);
      write_reg(CSR_SELF, self_bit);
      write_reg(CSR_OWN, own);
      csr_write <= 1'b0;
      quiet = ($urandom_range(0, 3) == 0);
   endtask

   task automatic random_frames(int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 15);
         if (pick < 7) plain_frame($urandom_range(1, 5), 0);
         else if (pick < 12) agg_frame();
         else if (pick < 13) plain_frame($urandom_range(1, 5), $urandom_range(1, hdr_bytes()));
         else if (pick < 14) plain_frame($urandom_range(4, 5), hdr_bytes() + $urandom_range(0, 3));
         else noise_frame();
      end
   endtask

   initial begin
      for (int i = 0; i < 6; i++) cfg_w[i] = 1;
      cfg_own = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      configure(1, 1, 1, 1, 1, 1, 1'b0, 32'd0);
      quiet = 1'b0;
      for (int k = 1; k <= 5; k++) plain_frame(k, 0);
      agg_frame();
      frame_q = '{8'd0, 8'd7};
      send_frame();
      frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame();
      frame_q = '{8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      send_frame();
      frame_q = '{8'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd6, 8'hAA};
      send_frame();
      frame_q = '{8'd1};
      send_frame();
      plain_frame(3, 4);

      configure(4, 4, 4, 4, 4, 4, 1'b1, 32'hFFFF_FFFF);
      random_frames(12);
      configure(0, 0, 0, 0, 0, 0, 1'b1, 32'd0);
      random_frames(10);
      configure(7, 6, 5, 7, 6, 5, 1'b0, 32'hFFFF_FFFF);
      random_frames(10);
      configure(0, 4, 1, 0, 4, 1, 1'b1, 32'd0);
      random_frames(10);
      while (beats_sent < 1550) begin
         configure($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(1, 4),
                   $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 4),
                   $urandom_range(0, 1), $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom);
         random_frames(8);
      end

      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fails == 0) $display("[frame_header_parser_with_deaggregation] OK");
      else $display("[frame_header_parser_with_deaggregation] ERROR");
      $finish;
   end

endmodule
